### src/ttra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttra_pkg
// Shared types, constants and register indexes of the thermal throttle rate
// aggregator.
// ----------------------------------------------------------------------------
package ttra_pkg;

    localparam int DEF_NUM_DEVICES = 4;
    localparam int DEF_NUM_CLOCKS  = 2;

    localparam int RATE_W   = 32;
    localparam int DEV_IN_W = 2;
    localparam int STATE_W  = 10;
    localparam int SLOPE_W  = 10;
    localparam int OFFS_W   = 31;
    localparam int KHZ_W    = 23;
    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    // state * step * percent scale fits in 49 bits
    localparam int PROD1_W = STATE_W + RATE_W;
    localparam int PROD_W  = PROD1_W + 7;

    localparam logic [6:0] PERCENT_SCALE = 7'd100;

    // x / 1000 == (x * KHZ_MAGIC) >> KHZ_SHIFT for every 32-bit x
    localparam int KHZ_MAGIC_W = 29;
    localparam logic [KHZ_MAGIC_W-1:0] KHZ_MAGIC = 29'd274877907;
    localparam int KHZ_SHIFT  = 38;
    localparam int KHZ_PROD_W = RATE_W + KHZ_MAGIC_W;

    localparam logic [RATE_W-1:0] RST_CPU_MAX  = 32'd1479000000;
    localparam logic [RATE_W-1:0] RST_CPU_MIN  = 32'd102000000;
    localparam logic [RATE_W-1:0] RST_GPU_MAX  = 32'd921600000;
    localparam logic [RATE_W-1:0] RST_GPU_MIN  = 32'd76800000;
    localparam logic [RATE_W-1:0] RST_CPU_STEP = 32'd76800000;
    localparam logic [RATE_W-1:0] RST_GPU_STEP = 32'd102000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CPU_MAX  = 3'd0,
        REG_CPU_MIN  = 3'd1,
        REG_GPU_MAX  = 3'd2,
        REG_GPU_MIN  = 3'd3,
        REG_CPU_STEP = 3'd4,
        REG_GPU_STEP = 3'd5
    } cfg_index_t;

    localparam logic CLK_CPU = 1'b0;

endpackage
`default_nettype wire

### src/ttra_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttra_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/thermal_throttle_rate_aggregator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermal_throttle_rate_aggregator_core
// Turns per-device cooling requests into a clamped clock rate, keeps a
// per-device, per-clock rate table and reports the lowest rate for the clock.
//
// Input stream s_*: one cooling request per transfer (device, state, slope,
// offset in tdata; clock select in tuser). Output stream m_*: one result per
// request (rate in Hz and kHz in tdata; clock id and changed flag in tuser).
// cfg_*: register writes (max/min rate and step per clock), taken any cycle.
// A request whose clock select is not below NUM_CLOCKS is dropped silently.
// One request is in flight at a time; each passes a 49-step shift-subtract
// divider and a scan of the rate table (one read per device on the memory's
// read port). Reset: registers take their defaults, then a clearing pass
// writes all ones to each of the 2^(DEV_W+CLK_W) table entries while
// s_tready stays low. A result waits in the output register while the
// receiver stalls; the next request is accepted meanwhile and its result
// holds back only until the output register frees.
// ----------------------------------------------------------------------------
module thermal_throttle_rate_aggregator_core #(
    parameter int NUM_DEVICES = ttra_pkg::DEF_NUM_DEVICES,
    parameter int NUM_CLOCKS  = ttra_pkg::DEF_NUM_CLOCKS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // device_index[1:0], cool_state[11:2], slope_percent[21:12],
    // offset[52:22], zero pad[55:53]
    input  wire logic [ttra_pkg::IN_DATA_W-1:0]     s_tdata,
    // clock_select[0]
    input  wire logic                               s_tuser,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // rate_hz[31:0], rate_khz[54:32], zero pad[55]
    output logic      [ttra_pkg::OUT_DATA_W-1:0]    m_tdata,
    // clock_id[0], rate_changed[1]
    output logic      [ttra_pkg::OUT_USER_W-1:0]    m_tuser,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ttra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ttra_pkg::RATE_W-1:0]        cfg_data
);

    import ttra_pkg::*;

    localparam int DEV_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int CLK_W = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
    localparam int AW    = DEV_W + CLK_W;
    localparam int DEPTH = 1 << AW;
    localparam int CNT_W = $clog2(NUM_DEVICES + 1);
    localparam int DIV_CNT_W = $clog2(PROD_W);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_SUB,
        ST_CLAMP,
        ST_WRITE,
        ST_SCAN,
        ST_KHZ,
        ST_FIN
    } fsm_t;

    fsm_t fsm_reg;

    // configuration
    logic [RATE_W-1:0] cpu_max_reg, cpu_min_reg, gpu_max_reg, gpu_min_reg;
    logic [RATE_W-1:0] cpu_step_reg, gpu_step_reg;

    // request fields
    logic [DEV_IN_W-1:0] in_dev;
    logic [STATE_W-1:0]  in_state;
    logic [SLOPE_W-1:0]  in_slope;
    logic [OFFS_W-1:0]   in_offset;
    logic [DEV_W+1:0]    dev_ext;
    logic [CLK_W:0]      clk_ext;
    logic                in_dev_ok, in_clk_ok;

    logic                dev_ok_reg;
    logic [DEV_W-1:0]    dev_idx_reg;
    logic [CLK_W-1:0]    clk_idx_reg;
    logic                clk_bit_reg;
    logic [STATE_W-1:0]  cool_reg;
    logic [SLOPE_W-1:0]  slope_reg;
    logic [OFFS_W-1:0]   offset_reg;

    // datapath
    logic [RATE_W-1:0]    max_sel, min_sel, step_sel;
    logic [PROD1_W-1:0]   prod1_reg;
    logic [PROD_W-1:0]    quot_reg;
    logic [SLOPE_W-1:0]   rem_reg;
    logic [SLOPE_W:0]     rem_trial, rem_diff;
    logic                 q_bit;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PROD_W-1:0]    offset_ext;
    logic [PROD_W-1:0]    amt_reg;
    logic [RATE_W-1:0]    rate_a, rate_b, rate_next, rate_reg;

    logic [CNT_W-1:0]     issue_cnt_reg;
    logic                 rd_pend_reg;
    logic [RATE_W-1:0]    lowest_reg;
    logic [KHZ_PROD_W-1:0] khz_prod_reg;

    logic [RATE_W-1:0]    applied_reg [NUM_CLOCKS];
    logic                 changed;

    logic                 out_valid_reg;
    logic                 out_clk_reg;
    logic [RATE_W-1:0]    out_hz_reg;
    logic [KHZ_W-1:0]     out_khz_reg;
    logic                 out_chg_reg;

    // table memory
    logic [AW-1:0]        clr_cnt_reg;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [RATE_W-1:0]    ram_wdata, ram_rdata;

    // ------------------------------------------------------------------ config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_max_reg  <= RST_CPU_MAX;
            cpu_min_reg  <= RST_CPU_MIN;
            gpu_max_reg  <= RST_GPU_MAX;
            gpu_min_reg  <= RST_GPU_MIN;
            cpu_step_reg <= RST_CPU_STEP;
            gpu_step_reg <= RST_GPU_STEP;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CPU_MAX:  cpu_max_reg  <= cfg_data;
                REG_CPU_MIN:  cpu_min_reg  <= cfg_data;
                REG_GPU_MAX:  gpu_max_reg  <= cfg_data;
                REG_GPU_MIN:  gpu_min_reg  <= cfg_data;
                REG_CPU_STEP: cpu_step_reg <= cfg_data;
                REG_GPU_STEP: gpu_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ input decode
    assign in_dev    = s_tdata[1:0];
    assign in_state  = s_tdata[11:2];
    assign in_slope  = s_tdata[21:12];
    assign in_offset = s_tdata[52:22];
    assign dev_ext   = (DEV_W + 2)'(in_dev);
    assign clk_ext   = (CLK_W + 1)'(s_tuser);
    assign in_dev_ok = ({30'd0, in_dev} < 32'(NUM_DEVICES));
    assign in_clk_ok = ({31'd0, s_tuser} < 32'(NUM_CLOCKS));

    assign s_tready = (fsm_reg == ST_IDLE);

    // ---------------------------------------------------------------- datapath
    assign max_sel  = (clk_bit_reg == CLK_CPU) ? cpu_max_reg  : gpu_max_reg;
    assign min_sel  = (clk_bit_reg == CLK_CPU) ? cpu_min_reg  : gpu_min_reg;
    assign step_sel = (clk_bit_reg == CLK_CPU) ? cpu_step_reg : gpu_step_reg;

    // restoring divide step; a zero slope yields an all-ones quotient
    assign rem_trial = {rem_reg, quot_reg[PROD_W-1]};
    assign rem_diff  = rem_trial - {1'b0, slope_reg};
    assign q_bit     = (rem_trial >= {1'b0, slope_reg});

    assign offset_ext = PROD_W'(offset_reg);

    always_comb begin
        if (amt_reg > PROD_W'(max_sel)) begin
            rate_a = min_sel;
        end else begin
            rate_a = max_sel - amt_reg[RATE_W-1:0];
        end
        rate_b    = (rate_a > max_sel) ? max_sel : rate_a;
        rate_next = (rate_b < min_sel) ? min_sel : rate_b;
    end

    assign changed = (lowest_reg != applied_reg[clk_idx_reg]);

    // ------------------------------------------------------------------ memory
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {clk_idx_reg, dev_idx_reg};
        ram_wdata = rate_reg;
        case (fsm_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '1;
            end
            ST_WRITE: ram_we = dev_ok_reg;
            default: ;
        endcase
    end

    assign ram_raddr = {clk_idx_reg, issue_cnt_reg[DEV_W-1:0]};

    ttra_ram #(
        .WIDTH (RATE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // --------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            div_cnt_reg   <= '0;
            for (int c = 0; c < NUM_CLOCKS; c++) begin
                applied_reg[c] <= '1;
            end
        end else begin
            if (out_valid_reg && m_tready && (fsm_reg != ST_FIN)) begin
                out_valid_reg <= 1'b0;
            end
            case (fsm_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                        fsm_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        dev_ok_reg  <= in_dev_ok;
                        dev_idx_reg <= dev_ext[DEV_W-1:0];
                        clk_idx_reg <= clk_ext[CLK_W-1:0];
                        clk_bit_reg <= s_tuser;
                        cool_reg    <= in_state;
                        slope_reg   <= in_slope;
                        offset_reg  <= in_offset;
                        if (in_clk_ok) begin
                            fsm_reg <= ST_MUL1;
                        end
                    end
                end
                ST_MUL1: begin
                    prod1_reg <= PROD1_W'(cool_reg) * PROD1_W'(step_sel);
                    fsm_reg   <= ST_MUL2;
                end
                ST_MUL2: begin
                    quot_reg    <= PROD_W'(prod1_reg) * PROD_W'(PERCENT_SCALE);
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    fsm_reg     <= ST_DIV;
                end
                ST_DIV: begin
                    quot_reg    <= {quot_reg[PROD_W-2:0], q_bit};
                    rem_reg     <= q_bit ? rem_diff[SLOPE_W-1:0] : rem_trial[SLOPE_W-1:0];
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(PROD_W - 1)) begin
                        fsm_reg <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    amt_reg <= (quot_reg > offset_ext) ? (quot_reg - offset_ext) : '0;
                    fsm_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    rate_reg <= rate_next;
                    fsm_reg  <= ST_WRITE;
                end
                ST_WRITE: begin
                    issue_cnt_reg <= '0;
                    rd_pend_reg   <= 1'b0;
                    lowest_reg    <= '1;
                    fsm_reg       <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (issue_cnt_reg < CNT_W'(NUM_DEVICES)) begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        rd_pend_reg   <= 1'b1;
                    end else begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg) begin
                            fsm_reg <= ST_KHZ;
                        end
                    end
                    if (rd_pend_reg && (ram_rdata < lowest_reg)) begin
                        lowest_reg <= ram_rdata;
                    end
                end
                ST_KHZ: begin
                    khz_prod_reg <= KHZ_PROD_W'(lowest_reg) * KHZ_PROD_W'(KHZ_MAGIC);
                    fsm_reg      <= ST_FIN;
                end
                ST_FIN: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_clk_reg   <= clk_bit_reg;
                        out_hz_reg    <= lowest_reg;
                        out_khz_reg   <= khz_prod_reg[KHZ_SHIFT +: KHZ_W];
                        out_chg_reg   <= changed;
                        if (changed) begin
                            applied_reg[clk_idx_reg] <= lowest_reg;
                        end
                        fsm_reg <= ST_IDLE;
                    end
                end
                default: fsm_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------ output
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_khz_reg, out_hz_reg};
    assign m_tuser  = {out_chg_reg, out_clk_reg};

endmodule
`default_nettype wire

### bench/thermal_throttle_rate_aggregator_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_throttle_rate_aggregator_core_checker
// Watches the request, result and register channels of the rate aggregator.
// It keeps its own copy of the clock limits, the per-device rate table and the
// last applied rate per clock. From these it works out the report that each
// accepted request must produce, and compares every returned report field by
// field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module thermal_throttle_rate_aggregator_core_checker #(
    parameter int NUM_DEVICES = ttra_pkg::DEF_NUM_DEVICES,
    parameter int NUM_CLOCKS  = ttra_pkg::DEF_NUM_CLOCKS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [ttra_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ttra_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic [ttra_pkg::OUT_USER_W-1:0]   m_tuser,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [ttra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttra_pkg::RATE_W-1:0]       cfg_data,
    output int                                mismatch_count,
    output int                                requests_pending
);
    import ttra_pkg::*;

    localparam logic CLK_GPU = !CLK_CPU;
    localparam longint unsigned HZ_PER_KHZ = 1000;

    typedef struct packed {
        logic              clock_id;
        logic [RATE_W-1:0] rate_hz;
        logic [KHZ_W-1:0]  rate_khz;
        logic              rate_changed;
    } rate_report_t;

    logic [RATE_W-1:0] clk_hi    [NUM_CLOCKS];
    logic [RATE_W-1:0] clk_lo    [NUM_CLOCKS];
    logic [RATE_W-1:0] step_rate [NUM_CLOCKS];
    logic [RATE_W-1:0] device_rate [NUM_DEVICES][NUM_CLOCKS];
    logic [RATE_W-1:0] applied [NUM_CLOCKS];

    rate_report_t report_q[$];
    int mismatches  = 0;
    int outstanding = 0;

    assign mismatch_count   = mismatches;
    assign requests_pending = outstanding;

    function automatic logic [RATE_W-1:0] limited_rate(
        input logic [STATE_W-1:0] cool,
        input logic [SLOPE_W-1:0] slope,
        input logic [OFFS_W-1:0]  offset,
        input logic [RATE_W-1:0]  hi,
        input logic [RATE_W-1:0]  lo,
        input logic [RATE_W-1:0]  step
    );
        logic [63:0] amount;
        logic [63:0] rate;
        if (slope == '0) begin
            amount = '1;
        end else begin
            amount = (64'(cool) * 64'(step) * 64'(PERCENT_SCALE)) / 64'(slope);
        end
        amount = (amount > 64'(offset)) ? amount - 64'(offset) : 64'd0;
        rate = (amount > 64'(hi)) ? 64'(lo) : 64'(hi) - amount;
        if (rate > 64'(hi)) rate = 64'(hi);
        if (rate < 64'(lo)) rate = 64'(lo);
        return rate[RATE_W-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        int                  accepted;
        int                  returned;
        rate_report_t        want;
        rate_report_t        got;
        logic [DEV_IN_W-1:0] dev;
        logic                clk_sel;
        logic [RATE_W-1:0]   lowest;
        if (!aresetn) begin
            clk_hi[CLK_CPU]    = RST_CPU_MAX;
            clk_lo[CLK_CPU]    = RST_CPU_MIN;
            step_rate[CLK_CPU] = RST_CPU_STEP;
            clk_hi[CLK_GPU]    = RST_GPU_MAX;
            clk_lo[CLK_GPU]    = RST_GPU_MIN;
            step_rate[CLK_GPU] = RST_GPU_STEP;
            for (int d = 0; d < NUM_DEVICES; d++) begin
                for (int c = 0; c < NUM_CLOCKS; c++) begin
                    device_rate[d][c] = '1;
                end
            end
            for (int c = 0; c < NUM_CLOCKS; c++) begin
                applied[c] = '1;
            end
            report_q.delete();
            outstanding <= 0;
        end else begin
            accepted = 0;
            returned = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CPU_MAX:  clk_hi[CLK_CPU]    = cfg_data;
                    REG_CPU_MIN:  clk_lo[CLK_CPU]    = cfg_data;
                    REG_GPU_MAX:  clk_hi[CLK_GPU]    = cfg_data;
                    REG_GPU_MIN:  clk_lo[CLK_GPU]    = cfg_data;
                    REG_CPU_STEP: step_rate[CLK_CPU] = cfg_data;
                    REG_GPU_STEP: step_rate[CLK_GPU] = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.clock_id     = m_tuser[0];
                got.rate_changed = m_tuser[1];
                got.rate_hz      = m_tdata[RATE_W-1:0];
                got.rate_khz     = m_tdata[RATE_W+KHZ_W-1:RATE_W];
                if (report_q.size() == 0) begin
                    $error("result with no request outstanding: clock_id %0d rate_hz %0d",
                           got.clock_id, got.rate_hz);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    returned = 1;
                    if (got.clock_id != want.clock_id) begin
                        $error("clock_id: expected %0d, got %0d", want.clock_id, got.clock_id);
                        mismatches++;
                    end
                    if (got.rate_hz != want.rate_hz) begin
                        $error("rate_hz: expected %0d, got %0d", want.rate_hz, got.rate_hz);
                        mismatches++;
                    end
                    if (got.rate_khz != want.rate_khz) begin
                        $error("rate_khz: expected %0d, got %0d", want.rate_khz, got.rate_khz);
                        mismatches++;
                    end
                    if (got.rate_changed != want.rate_changed) begin
                        $error("rate_changed: expected %0d, got %0d",
                               want.rate_changed, got.rate_changed);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                dev     = s_tdata[DEV_IN_W-1:0];
                clk_sel = s_tuser;
                if (int'(clk_sel) < NUM_CLOCKS) begin
                    if (int'(dev) < NUM_DEVICES) begin
                        device_rate[dev][clk_sel] = limited_rate(
                            s_tdata[DEV_IN_W +: STATE_W],
                            s_tdata[DEV_IN_W+STATE_W +: SLOPE_W],
                            s_tdata[DEV_IN_W+STATE_W+SLOPE_W +: OFFS_W],
                            clk_hi[clk_sel], clk_lo[clk_sel], step_rate[clk_sel]);
                    end
                    lowest = '1;
                    for (int d = 0; d < NUM_DEVICES; d++) begin
                        if (device_rate[d][clk_sel] < lowest) lowest = device_rate[d][clk_sel];
                    end
                    want.clock_id     = clk_sel;
                    want.rate_hz      = lowest;
                    want.rate_khz     = KHZ_W'(64'(lowest) / HZ_PER_KHZ);
                    want.rate_changed = (lowest != applied[clk_sel]);
                    applied[clk_sel]  = lowest;
                    report_q.push_back(want);
                    accepted = 1;
                end
            end
            outstanding <= outstanding + accepted - returned;
        end
    end

endmodule

### bench/thermal_throttle_rate_aggregator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_throttle_rate_aggregator_core_test
// Drives cooling requests and register writes into the rate aggregator under
// random sender and receiver stalls, and gives the verdict from the mismatch
// and pending-request counts of the checker. A directed part covers the field
// extremes, zero slope, minimum above maximum and ignored register indexes;
// random requests follow under several register settings.
// ----------------------------------------------------------------------------
module thermal_throttle_rate_aggregator_core_test;
    import ttra_pkg::*;

    localparam logic CLK_GPU   = !CLK_CPU;
    localparam int   REG_COUNT = 6;
    localparam int   SEGMENTS  = 6;
    localparam int   SEG_ITEMS = 200;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [RATE_W-1:0]     cfg_data  = '0;

    int mismatch_count;
    int requests_pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    thermal_throttle_rate_aggregator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    thermal_throttle_rate_aggregator_core_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count), .requests_pending(requests_pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    task automatic request(input logic [DEV_IN_W-1:0] dev, input logic clk_sel,
                           input logic [STATE_W-1:0] cool, input logic [SLOPE_W-1:0] slope,
                           input logic [OFFS_W-1:0] offset);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[DEV_IN_W-1:0]                        = dev;
        word[DEV_IN_W +: STATE_W]                 = cool;
        word[DEV_IN_W+STATE_W +: SLOPE_W]         = slope;
        word[DEV_IN_W+STATE_W+SLOPE_W +: OFFS_W]  = offset;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= clk_sel;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold requests until every report is back, then let the block settle
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (requests_pending != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    function automatic logic [RATE_W-1:0] random_rate();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(2_000_000_000, 500_000_000);
            4, 5: return $urandom_range(400_000_000, 20_000_000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] random_step();
        case ($urandom_range(7))
            0: return '0;
            1: return 1;
            2: return '1;
            3, 4, 5: return $urandom_range(1 << 20, 1);
            6: return $urandom_range(200_000_000, 1_000_000);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_setup();
        write_reg(REG_CPU_MAX, random_rate());
        write_reg(REG_CPU_MIN, random_rate());
        write_reg(REG_GPU_MAX, random_rate());
        write_reg(REG_GPU_MIN, random_rate());
        write_reg(REG_CPU_STEP, random_step());
        write_reg(REG_GPU_STEP, random_step());
        if ($urandom_range(1)) write_reg(CFG_IDX_W'(REG_COUNT + $urandom_range(1)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [STATE_W-1:0] cool;
        logic [SLOPE_W-1:0] slope;
        logic [OFFS_W-1:0]  offset;
        case ($urandom_range(9))
            0: cool = '0;
            1: cool = '1;
            2, 3, 4, 5: cool = STATE_W'($urandom_range(15));
            default: cool = STATE_W'($urandom_range(1023));
        endcase
        case ($urandom_range(15))
            0: slope = '0;
            1: slope = 1;
            2: slope = '1;
            3, 4, 5, 6, 7, 8: slope = SLOPE_W'($urandom_range(400, 100));
            default: slope = SLOPE_W'($urandom_range(1023));
        endcase
        case ($urandom_range(7))
            0: offset = '0;
            1: offset = '1;
            2, 3, 4: offset = OFFS_W'($urandom_range(1 << 24));
            default: offset = OFFS_W'($urandom());
        endcase
        request(DEV_IN_W'($urandom_range(3)), 1'($urandom_range(1)), cool, slope, offset);
    endtask

    initial begin
        send_idle_pct = 24;
        recv_idle_pct = 56;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limits: unthrottled, saturated, zero slope, exact offset
        request(0, CLK_CPU, 0, 1, 0);
        request(0, CLK_CPU, 0, 1, 0);
        request(1, CLK_CPU, '1, 1, 0);
        request(2, CLK_GPU, '1, '0, 0);
        request(3, CLK_GPU, '1, '1, '1);
        request(3, CLK_CPU, 5, 100, 0);
        request(2, CLK_CPU, 1, 100, OFFS_W'(RST_CPU_STEP));
        request(1, CLK_GPU, '1, '1, 0);
        request(0, CLK_GPU, 0, '0, '1);

        // widest CPU range, GPU minimum above maximum, ignored indexes
        drain(4);
        write_reg(REG_CPU_MAX, '1);
        write_reg(REG_CPU_MIN, '0);
        write_reg(REG_CPU_STEP, '1);
        write_reg(REG_GPU_MAX, '0);
        write_reg(REG_GPU_MIN, '1);
        write_reg(REG_GPU_STEP, 1);
        write_reg(CFG_IDX_W'(REG_COUNT), $urandom());
        write_reg(CFG_IDX_W'(REG_COUNT + 1), $urandom());
        cfg_valid <= 1'b0;
        request(0, CLK_CPU, '1, 1, 0);
        request(1, CLK_CPU, 0, '1, '1);
        request(2, CLK_GPU, '1, 1, 0);
        request(3, CLK_GPU, 0, '0, 0);
        request(3, CLK_CPU, 1, '1, '1);

        // everything zero
        drain(4);
        write_reg(REG_CPU_MAX, '0);
        write_reg(REG_CPU_MIN, '0);
        write_reg(REG_CPU_STEP, '0);
        write_reg(REG_GPU_MAX, '0);
        write_reg(REG_GPU_MIN, '0);
        write_reg(REG_GPU_STEP, '0);
        cfg_valid <= 1'b0;
        request(0, CLK_CPU, '1, '0, '1);
        request(1, CLK_GPU, '1, '1, 0);
        request(2, CLK_CPU, 0, 1, 0);
        request(3, CLK_GPU, 1, 1, 1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain(4);
            random_setup();
            for (int i = 0; i < SEG_ITEMS; i++) begin
                if (i == SEG_ITEMS / 2) drain(0);
                random_request();
            end
        end

        drain(80);
        if (mismatch_count == 0 && requests_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
